// File: rtl/core/utf8_decode_width_measure_top_defines.svh
// ----------------------------------------------------------------------------
// utf8 width measure assertion macros
// shared assertion forms for the utf8 width measure block
// ----------------------------------------------------------------------------
`ifndef UTF8_DECODE_WIDTH_MEASURE_TOP_DEFINES_SVH
`define UTF8_DECODE_WIDTH_MEASURE_TOP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define UDW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("utf8 width measure check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define UDW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("utf8 width measure check failed");

`endif

// File: rtl/core/utf8dw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8dw_pkg
// types, constants and decode tables of the utf8 width measure block
// ----------------------------------------------------------------------------
package utf8dw_pkg;

    localparam int C_BYTE_W      = 8;
    localparam int C_CP_W        = 21;
    localparam int C_STATE_W     = 4;
    localparam int C_CLASS_W     = 4;
    localparam int C_GLYPH_W     = 8;
    localparam int C_TOTAL_W     = 20;
    localparam int C_CFG_IDX_W   = 3;
    localparam int C_CFG_DATA_W  = 21;
    localparam int C_WIDTH_SUM_BITS = 20;

    // register indexes
    localparam logic [C_CFG_IDX_W-1:0] CFG_NARROW_WIDTH = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_WIDE_WIDTH   = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] CFG_WIDE_LOW     = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] CFG_WIDE_HIGH    = 3'd3;

    // dfa states with a meaning of their own
    localparam logic [C_STATE_W-1:0] DFA_ACCEPT = 4'd0;
    localparam logic [C_STATE_W-1:0] DFA_REJECT = 4'd1;
    localparam logic [C_STATE_W-1:0] DFA_LAST   = 4'd8;

    typedef enum logic [1:0] {
        STATUS_PENDING  = 2'd0,
        STATUS_COMPLETE = 2'd1,
        STATUS_REJECTED = 2'd2
    } t_status;

    typedef struct packed {
        logic [C_STATE_W-1:0] state;
        logic [C_CP_W-1:0]    accum;
    } t_dfa_res;

    // transition table, row = state, column = byte class
    localparam logic [C_STATE_W-1:0] C_NEXT_STATE [0:143] = '{
        4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,4'd1,4'd1,4'd1,4'd1,
        4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
        4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
        4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
        4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
        4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
        4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
        4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
        4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1
    };

    // byte class lookup
    function automatic logic [C_CLASS_W-1:0] f_byte_class(input logic [C_BYTE_W-1:0] b);
        logic [C_CLASS_W-1:0] cls;
        case (b) inside
            [8'h00:8'h7f]: cls = 4'd0;
            [8'h80:8'h8f]: cls = 4'd1;
            [8'h90:8'h9f]: cls = 4'd9;
            [8'ha0:8'hbf]: cls = 4'd7;
            8'hc0, 8'hc1:  cls = 4'd8;
            [8'hc2:8'hdf]: cls = 4'd2;
            8'he0:         cls = 4'd10;
            8'hed:         cls = 4'd4;
            [8'he1:8'hef]: cls = 4'd3;
            8'hf0:         cls = 4'd11;
            [8'hf1:8'hf3]: cls = 4'd6;
            8'hf4:         cls = 4'd5;
            default:       cls = 4'd8;
        endcase
        return cls;
    endfunction

endpackage

// File: rtl/core/utf8_decode_width_measure_top.sv
// an accepted byte's result word is registered and on the output in the next cycle
// throughput: one byte per cycle while output words are taken, set by the decoder state loop
// output register frees up as its word is taken, so bytes stream without gaps
// reset: synchronous, active low; clears decoder state, width, flags; sets config to defaults
`timescale 1ns / 1ps
`include "utf8_decode_width_measure_top_defines.svh"
// ----------------------------------------------------------------------------
// utf8_decode_width_measure_top
// validating utf8 decoder with wide-glyph classification and running width
// ----------------------------------------------------------------------------
module utf8_decode_width_measure_top #(
    parameter int WIDTH_SUM_BITS = utf8dw_pkg::C_WIDTH_SUM_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input byte channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [utf8dw_pkg::C_BYTE_W-1:0]      i_text_byte,
    input  logic                                 i_string_start,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [1:0]                           o_decode_status,
    output logic [utf8dw_pkg::C_CP_W-1:0]        o_codepoint,
    output logic                                 o_is_wide,
    output logic [utf8dw_pkg::C_TOTAL_W-1:0]     o_total_width,
    output logic                                 o_has_wide,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [utf8dw_pkg::C_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [utf8dw_pkg::C_CFG_DATA_W-1:0]  i_cfg_data
);
    import utf8dw_pkg::*;

    // configuration registers
    logic [C_GLYPH_W-1:0] r_narrow_width;
    logic [C_GLYPH_W-1:0] r_wide_width;
    logic [C_CP_W-1:0]    r_wide_low;
    logic [C_CP_W-1:0]    r_wide_high;

    // decoder state carried between bytes
    logic [C_STATE_W-1:0]      r_state;
    logic [C_CP_W-1:0]         r_accum;
    logic [WIDTH_SUM_BITS-1:0] r_width_sum;
    logic                      r_wide_seen;

    // result word register
    logic                 r_out_valid;
    t_status              r_status;
    logic [C_CP_W-1:0]    r_codepoint;
    logic                 r_is_wide;

    // next values
    logic [C_STATE_W-1:0]      n_state;
    logic [C_CP_W-1:0]         n_accum;
    logic [WIDTH_SUM_BITS-1:0] n_width_sum;
    logic                      n_wide_seen;
    t_status                   n_status;
    logic [C_CP_W-1:0]         n_codepoint;
    logic                      n_is_wide;

    // state as seen by this byte, after a string start
    logic [C_STATE_W-1:0]      cur_state;
    logic [C_CP_W-1:0]         cur_accum;
    logic [WIDTH_SUM_BITS-1:0] cur_width_sum;
    logic                      cur_wide_seen;

    logic                      in_fire;
    logic                      wide_hit;
    logic [C_GLYPH_W-1:0]      glyph_add;
    logic [WIDTH_SUM_BITS:0]   sum_ext;
    t_dfa_res                  dfa_res;

    // a word can enter whenever the result slot is empty or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // string start wipes the carried state before the byte is decoded
    always_comb begin
        cur_state     = i_string_start ? DFA_ACCEPT : r_state;
        cur_accum     = i_string_start ? '0 : r_accum;
        cur_width_sum = i_string_start ? '0 : r_width_sum;
        cur_wide_seen = i_string_start ? 1'b0 : r_wide_seen;
    end

    utf8dw_dfa u_dfa (
        .i_state (cur_state),
        .i_accum (cur_accum),
        .i_byte  (i_text_byte),
        .o_res   (dfa_res)
    );

    // next state, status and width bookkeeping for a completed codepoint
    always_comb begin
        n_state     = dfa_res.state;
        n_accum     = dfa_res.accum;
        // an empty range (low above high) never matches
        wide_hit    = (dfa_res.accum >= r_wide_low) && (dfa_res.accum <= r_wide_high);
        glyph_add   = wide_hit ? r_wide_width : r_narrow_width;
        sum_ext     = {1'b0, cur_width_sum} + (WIDTH_SUM_BITS + 1)'(glyph_add);
        n_width_sum = cur_width_sum;
        n_wide_seen = cur_wide_seen;
        n_status    = STATUS_PENDING;
        n_codepoint = '0;
        n_is_wide   = 1'b0;
        if (dfa_res.state == DFA_ACCEPT) begin
            n_status    = STATUS_COMPLETE;
            n_codepoint = dfa_res.accum;
            n_is_wide   = wide_hit;
            // saturate on carry out of the sum
            n_width_sum = sum_ext[WIDTH_SUM_BITS] ? '1 : sum_ext[WIDTH_SUM_BITS-1:0];
            n_wide_seen = cur_wide_seen || wide_hit;
        end else if (dfa_res.state == DFA_REJECT) begin
            n_status = STATUS_REJECTED;
        end
    end

    // control state, configuration and carried decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_state        <= DFA_ACCEPT;
            r_accum        <= '0;
            r_width_sum    <= '0;
            r_wide_seen    <= 1'b0;
            r_narrow_width <= 8'd8;
            r_wide_width   <= 8'd16;
            r_wide_low     <= 21'h10ffff;
            r_wide_high    <= '0;
        end else begin
            if (in_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_accum     <= n_accum;
                r_width_sum <= n_width_sum;
                r_wide_seen <= n_wide_seen;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_NARROW_WIDTH: r_narrow_width <= i_cfg_data[C_GLYPH_W-1:0];
                    CFG_WIDE_WIDTH:   r_wide_width   <= i_cfg_data[C_GLYPH_W-1:0];
                    CFG_WIDE_LOW:     r_wide_low     <= i_cfg_data[C_CP_W-1:0];
                    CFG_WIDE_HIGH:    r_wide_high    <= i_cfg_data[C_CP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // result payload, loaded with each accepted byte
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status    <= n_status;
            r_codepoint <= n_codepoint;
            r_is_wide   <= n_is_wide;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_decode_status = r_status;
    assign o_codepoint     = r_codepoint;
    assign o_is_wide       = r_is_wide;
    // running width and flag only change with a new byte, so the carried
    // state is exactly the value belonging to the word on the output
    assign o_has_wide      = r_wide_seen;

    generate
        if (WIDTH_SUM_BITS >= C_TOTAL_W) begin : g_total_trunc
            assign o_total_width = r_width_sum[C_TOTAL_W-1:0];
        end else begin : g_total_ext
            assign o_total_width = {{(C_TOTAL_W - WIDTH_SUM_BITS){1'b0}}, r_width_sum};
        end
    endgenerate

    // incomplete results carry no codepoint and no wide mark
    `UDW_ASSERT_NOW(a_idle_fields_zero, o_out_valid && (r_status != STATUS_COMPLETE), (o_codepoint == '0) && !o_is_wide)
    // a wide glyph on the output implies the sticky flag is set
    `UDW_ASSERT_NOW(a_wide_sets_flag, o_out_valid && o_is_wide, o_has_wide)
    // reject sticks until a string start
    `UDW_ASSERT_NEXT(a_reject_sticky, i_rst_n && in_fire && !i_string_start && (r_state == DFA_REJECT), r_status == STATUS_REJECTED)

endmodule

// File: rtl/core/utf8dw_dfa.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8dw_dfa
// one byte step of the validating utf8 decoder: class, transition, accumulate
// ----------------------------------------------------------------------------
module utf8dw_dfa (
    input  logic [utf8dw_pkg::C_STATE_W-1:0] i_state,
    input  logic [utf8dw_pkg::C_CP_W-1:0]    i_accum,
    input  logic [utf8dw_pkg::C_BYTE_W-1:0]  i_byte,
    output utf8dw_pkg::t_dfa_res             o_res
);
    import utf8dw_pkg::*;

    logic [C_CLASS_W-1:0] cls;
    logic [C_STATE_W-1:0] state_safe;
    logic [C_BYTE_W-1:0]  lead_mask;

    always_comb begin
        cls        = f_byte_class(i_byte);
        // states past the table fall into reject
        state_safe = (i_state > DFA_LAST) ? DFA_REJECT : i_state;
        lead_mask  = 8'hff >> cls;
        if (state_safe != DFA_ACCEPT) begin
            o_res.accum = {i_accum[C_CP_W-7:0], i_byte[5:0]};
        end else begin
            o_res.accum = C_CP_W'(lead_mask & i_byte);
        end
        o_res.state = C_NEXT_STATE[{state_safe, cls}];
    end

endmodule
